### rtl/core/digit_blink_code_led_driver_assert.svh
// assertion macros for the blink-code led driver
`ifndef DIGIT_BLINK_CODE_LED_DRIVER_ASSERT_SVH
`define DIGIT_BLINK_CODE_LED_DRIVER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define DBCLED_ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("dbcled: same-cycle check failed");

// condition holds in the cycle after the trigger
`define DBCLED_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("dbcled: next-cycle check failed");

`endif

### rtl/core/dbcled_pkg.sv
// shared types and constants for the blink-code led driver
`timescale 1ns / 1ps
`default_nettype none

package dbcled_pkg;

   // input beat
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] value;
   } req_type;

   // result beat
   typedef struct packed {
      logic led_on;
      logic showing_tens;
      logic long_rest;
   } rsp_type;

   // op codes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // register indexes
   localparam logic [2:0] REG_SLOW_INTERVAL = 3'd0;
   localparam logic [2:0] REG_FAST_INTERVAL = 3'd1;
   localparam logic [2:0] REG_LONG_PAUSE    = 3'd2;
   localparam logic [2:0] REG_ZERO_PAUSE    = 3'd3;
   localparam logic [2:0] REG_NONZERO_PAUSE = 3'd4;
   localparam logic [2:0] REG_MAX_HUNDREDS  = 3'd5;

   // register reset values
   localparam logic [11:0] SLOW_INTERVAL_RST = 12'd400;
   localparam logic [11:0] FAST_INTERVAL_RST = 12'd150;
   localparam logic [11:0] LONG_PAUSE_RST    = 12'd3000;
   localparam logic [3:0]  ZERO_PAUSE_RST    = 4'd2;
   localparam logic [3:0]  NONZERO_PAUSE_RST = 4'd3;
   localparam logic [3:0]  MAX_HUNDREDS_RST  = 4'd12;

   // digit split: reciprocal multiply, exact over the 16-bit range
   localparam logic [13:0] HUNDRED_RECIP = 14'd10486;  // 2^18 / 25 rounded up, on value / 4
   localparam logic [6:0]  HUNDRED       = 7'd100;
   localparam logic [7:0]  TEN_RECIP     = 8'd205;     // 2^11 / 10, rounded up
   localparam logic [3:0]  TENS_LIMIT    = 4'd9;
   localparam logic [11:0] ELAPSED_MAX   = 12'hFFF;

endpackage

`default_nettype wire

### rtl/core/digit_blink_code_led_driver.sv
// Blink-code LED driver: shows the hundreds digit (clamped) and then the tens
// digit of a stored number as counts of blinks on one LED, stepping on
// millisecond tick beats. Every input beat (tick, load, load and restart, or
// an unused op code) yields exactly one result beat with the LED level and
// phase flags after that beat. The block takes one beat per clock cycle
// while the output is not stalled; a beat passes an input register and then
// the digit split and step logic into the result register, from which its
// result beat is offered. The result register and the input register
// together let a new beat enter while a finished result waits on a stalled
// output. The user must write registers through the csr port only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "digit_blink_code_led_driver_assert.svh"

module digit_blink_code_led_driver (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire dbcled_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output dbcled_pkg::rsp_type     rsp_payload,
   input  wire logic               csr_wen,
   input  wire logic [2:0]         csr_index,
   input  wire logic [11:0]        csr_wdata
);
   import dbcled_pkg::*;

   // configuration registers
   logic [11:0] slow_interval_ff, fast_interval_ff, long_pause_ms_ff;
   logic [3:0]  zero_pause_ff, nonzero_pause_ff, max_hundreds_ff;

   // pipeline registers
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // display state
   logic [3:0]  hundreds_ff, hundreds_in;
   logic [3:0]  tens_digit_ff, tens_digit_in;
   logic        tens_phase_ff, tens_phase_in;
   logic [3:0]  blinks_ff, blinks_in;
   logic        lit_ff, lit_in;
   logic [3:0]  pause_ff, pause_in;
   logic        long_pause_ff, long_pause_in;
   logic [11:0] elapsed_ff, elapsed_in;
   logic        led_ff, led_in;

   logic accept, out_free, fire;

   // digit split
   logic [27:0] hq_prod;
   logic [9:0]  hq;
   logic [16:0] h_times_100;
   logic [6:0]  rem100;
   logic [14:0] tq_prod;
   logic [3:0]  tq;
   logic [3:0]  h_clamped, t_clamped;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? fire : rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // value / 100 as (value / 4) / 25, and (value mod 100) / 10
   assign hq_prod     = 28'(s1_req_ff.value[15:2]) * 28'(HUNDRED_RECIP);
   assign hq          = hq_prod[27:18];
   assign h_times_100 = 17'(hq) * 17'(HUNDRED);
   assign rem100      = 7'(17'(s1_req_ff.value) - h_times_100);
   assign tq_prod     = 15'(rem100) * 15'(TEN_RECIP);
   assign tq          = tq_prod[14:11];
   assign h_clamped   = (hq > 10'(max_hundreds_ff)) ? max_hundreds_ff : hq[3:0];
   assign t_clamped   = (tq > TENS_LIMIT) ? TENS_LIMIT : tq;

   // next display state for the beat in the input register
   always_comb begin
      logic [11:0] el;
      logic [11:0] interval;
      logic [3:0]  digit;
      logic [3:0]  limit;
      logic        do_close;
      hundreds_in   = hundreds_ff;
      tens_digit_in = tens_digit_ff;
      tens_phase_in = tens_phase_ff;
      blinks_in     = blinks_ff;
      lit_in        = lit_ff;
      pause_in      = pause_ff;
      long_pause_in = long_pause_ff;
      elapsed_in    = elapsed_ff;
      led_in        = led_ff;
      el            = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 12'd1 : elapsed_ff;
      interval      = tens_phase_ff ? fast_interval_ff : slow_interval_ff;
      digit         = tens_phase_ff ? tens_digit_ff : hundreds_ff;
      limit         = nonzero_pause_ff;
      do_close      = 1'b0;
      case (s1_req_ff.op)
         OP_TICK: begin
            elapsed_in = el;
            if (long_pause_ff && el < long_pause_ms_ff) begin
               // still in the long pause
            end else begin
               long_pause_in = 1'b0;
               if (el >= interval) begin
                  elapsed_in = 12'd0;
                  // one step of the blink sequence
                  if (digit == 4'd0) begin
                     if (blinks_ff == 4'd0) begin
                        led_in    = 1'b1;
                        blinks_in = 4'd1;
                     end else begin
                        do_close = 1'b1;
                        limit    = zero_pause_ff;
                     end
                  end else if (blinks_ff < digit) begin
                     lit_in = !lit_ff;
                     if (!lit_ff) begin
                        led_in = 1'b1;
                     end else begin
                        led_in    = 1'b0;
                        blinks_in = blinks_ff + 4'd1;
                     end
                  end else begin
                     lit_in   = 1'b0;
                     do_close = 1'b1;
                  end
                  // dark pause closing a digit
                  if (do_close) begin
                     led_in   = 1'b0;
                     pause_in = pause_ff + 4'd1;
                     if (pause_in >= limit) begin
                        pause_in      = 4'd0;
                        blinks_in     = 4'd0;
                        tens_phase_in = !tens_phase_ff;
                        if (tens_phase_ff) begin
                           long_pause_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         OP_LOAD: begin
            hundreds_in   = h_clamped;
            tens_digit_in = t_clamped;
         end
         OP_RESTART: begin
            hundreds_in   = h_clamped;
            tens_digit_in = t_clamped;
            tens_phase_in = 1'b0;
            blinks_in     = 4'd0;
            lit_in        = 1'b0;
            pause_in      = 4'd0;
            long_pause_in = 1'b0;
            elapsed_in    = 12'd0;
         end
         default: begin
         end
      endcase
      rsp_in.led_on       = led_in;
      rsp_in.showing_tens = tens_phase_in;
      rsp_in.long_rest    = long_pause_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_interval_ff <= SLOW_INTERVAL_RST;
         fast_interval_ff <= FAST_INTERVAL_RST;
         long_pause_ms_ff <= LONG_PAUSE_RST;
         zero_pause_ff    <= ZERO_PAUSE_RST;
         nonzero_pause_ff <= NONZERO_PAUSE_RST;
         max_hundreds_ff  <= MAX_HUNDREDS_RST;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         hundreds_ff      <= 4'd0;
         tens_digit_ff    <= 4'd0;
         tens_phase_ff    <= 1'b0;
         blinks_ff        <= 4'd0;
         lit_ff           <= 1'b0;
         pause_ff         <= 4'd0;
         long_pause_ff    <= 1'b0;
         elapsed_ff       <= 12'd0;
         led_ff           <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               REG_SLOW_INTERVAL: slow_interval_ff <= csr_wdata;
               REG_FAST_INTERVAL: fast_interval_ff <= csr_wdata;
               REG_LONG_PAUSE:    long_pause_ms_ff <= csr_wdata;
               REG_ZERO_PAUSE:    zero_pause_ff    <= csr_wdata[3:0];
               REG_NONZERO_PAUSE: nonzero_pause_ff <= csr_wdata[3:0];
               REG_MAX_HUNDREDS:  max_hundreds_ff  <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
         if (fire) begin
            hundreds_ff   <= hundreds_in;
            tens_digit_ff <= tens_digit_in;
            tens_phase_ff <= tens_phase_in;
            blinks_ff     <= blinks_in;
            lit_ff        <= lit_in;
            pause_ff      <= pause_in;
            long_pause_ff <= long_pause_in;
            elapsed_ff    <= elapsed_in;
            led_ff        <= led_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   `DBCLED_ASSERT_IMPLY(a_dark_in_pause, clock, reset, long_pause_ff, !led_ff)
   `DBCLED_ASSERT_IMPLY(a_pause_in_hundreds, clock, reset, long_pause_ff, !tens_phase_ff)
   `DBCLED_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, s1_valid_ff && out_free, rsp_valid)

endmodule

`default_nettype wire

### sim/digit_blink_code_led_driver_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the blink-code led driver: directed table, then random phases
module digit_blink_code_led_driver_tb;
   import dbcled_pkg::*;

   // op code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int NUM_PHASES       = 10;
   localparam int PHASE_BEATS      = 110;
   localparam int LONG_PHASE_BEATS = 1000;
   localparam int HOLD_AT          = 300;
   localparam int HOLD_CYCLES      = 40;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int DRAIN_CYCLES     = 8;

   // one directed step: either a register write or an input beat
   typedef struct packed {
      logic        is_csr;
      logic [2:0]  csr_idx;
      logic [11:0] csr_val;
      req_type     beat;
      logic        known;
      rsp_type     want;
   } table_row_type;

   // want fields: led, tens phase, long pause
   localparam table_row_type DIR_ROWS [0:34] = '{
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_UNUSED, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_LOAD, 16'd65535}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_RESTART, 16'd0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{1'b1, REG_SLOW_INTERVAL, 12'd1, '0, 1'b0, '0},
      '{1'b1, REG_FAST_INTERVAL, 12'd1, '0, 1'b0, '0},
      '{1'b1, REG_LONG_PAUSE, 12'd1, '0, 1'b0, '0},
      '{1'b1, REG_ZERO_PAUSE, 12'd1, '0, 1'b0, '0},
      '{1'b1, REG_NONZERO_PAUSE, 12'd1, '0, 1'b0, '0},
      '{1'b1, REG_MAX_HUNDREDS, 12'd15, '0, 1'b0, '0},
      // zero hundreds digit: one short blink, then dark, then tens
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b0, 1'b1, 1'b0}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b1, 1'b1, 1'b0}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b1, 1'b0, 1'b0}},
      // restart keeps the led level, hundreds clamp to the max
      '{1'b0, '0, '0, '{OP_RESTART, 16'd65535}, 1'b1, '{1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b1, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      // digit lowered to the blink count: straight to the dark pause
      '{1'b0, '0, '0, '{OP_LOAD, 16'd150}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b1, '{1'b0, 1'b1, 1'b0}},
      '{1'b1, REG_MAX_HUNDREDS, 12'd0, '0, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_LOAD, 16'd999}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'hFFFF}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0},
      // zero interval and zero pause lengths
      '{1'b1, REG_ZERO_PAUSE, 12'd0, '0, 1'b0, '0},
      '{1'b1, REG_NONZERO_PAUSE, 12'd0, '0, 1'b0, '0},
      '{1'b1, REG_SLOW_INTERVAL, 12'd0, '0, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_RESTART, 16'h5555}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_LOAD, 16'hAAAA}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0},
      '{1'b0, '0, '0, '{OP_TICK, 16'd0}, 1'b0, '0}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wen     = 1'b0;
   logic [2:0]  csr_index   = REG_SLOW_INTERVAL;
   logic [11:0] csr_wdata   = '0;

   // register copy
   logic [11:0] slow_ms      = SLOW_INTERVAL_RST;
   logic [11:0] fast_ms      = FAST_INTERVAL_RST;
   logic [11:0] rest_ms      = LONG_PAUSE_RST;
   logic [3:0]  zero_dark    = ZERO_PAUSE_RST;
   logic [3:0]  nonzero_dark = NONZERO_PAUSE_RST;
   logic [3:0]  hund_max     = MAX_HUNDREDS_RST;

   // blink sequencer copy
   logic [3:0]  hund_digit = '0;
   logic [3:0]  tens_digit = '0;
   logic        in_tens    = 1'b0;
   logic [3:0]  blink_cnt  = '0;
   logic        lit        = 1'b0;
   logic [3:0]  dark_cnt   = '0;
   logic        resting    = 1'b0;
   logic [11:0] ms_count   = '0;
   logic        led        = 1'b0;

   rsp_type led_due [$];
   int      errors       = 0;
   int      quiet_cycles = 0;
   logic    send_eager   = 1'b0;

   digit_blink_code_led_driver i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // digit split with clamp on the hundreds
   function automatic void load_digits(input logic [15:0] v);
      logic [15:0] h;
      logic [15:0] t;
      h = v / 16'd100;
      t = (v % 16'd100) / 16'd10;
      if (h > 16'(hund_max)) h = 16'(hund_max);
      hund_digit = h[3:0];
      tens_digit = t[3:0];
   endfunction

   // one dark step at the end of a digit; last one flips the phase
   function automatic void end_digit(input logic [3:0] limit);
      led      = 1'b0;
      dark_cnt = dark_cnt + 4'd1;
      if (dark_cnt >= limit) begin
         dark_cnt  = '0;
         blink_cnt = '0;
         in_tens   = ~in_tens;
         if (!in_tens) begin
            resting  = 1'b1;
            ms_count = '0;
         end
      end
   endfunction

   function automatic void take_step();
      logic [3:0] digit;
      digit = in_tens ? tens_digit : hund_digit;
      if (digit == 4'd0) begin
         if (blink_cnt == 4'd0) begin
            led       = 1'b1;
            blink_cnt = 4'd1;
         end else begin
            end_digit(zero_dark);
         end
      end else if (blink_cnt < digit) begin
         lit = ~lit;
         if (lit) begin
            led = 1'b1;
         end else begin
            led       = 1'b0;
            blink_cnt = blink_cnt + 4'd1;
         end
      end else begin
         lit = 1'b0;
         end_digit(nonzero_dark);
      end
   endfunction

   // millisecond tick: saturating count, long pause, then step timer
   function automatic void count_ms();
      logic [11:0] interval;
      if (ms_count != ELAPSED_MAX) ms_count = ms_count + 12'd1;
      if (resting && ms_count < rest_ms) return;
      resting  = 1'b0;
      interval = in_tens ? fast_ms : slow_ms;
      if (ms_count >= interval) begin
         ms_count = '0;
         take_step();
      end
   endfunction

   function automatic rsp_type next_led_state(input req_type b);
      rsp_type r;
      case (b.op)
         OP_TICK: count_ms();
         OP_LOAD: load_digits(b.value);
         OP_RESTART: begin
            load_digits(b.value);
            in_tens   = 1'b0;
            blink_cnt = '0;
            lit       = 1'b0;
            dark_cnt  = '0;
            resting   = 1'b0;
            ms_count  = '0;
         end
         default: ;
      endcase
      r.led_on       = led;
      r.showing_tens = in_tens;
      r.long_rest    = resting;
      return r;
   endfunction

   // register write, mirrored into the local copy
   task automatic write_csr(input logic [2:0] idx, input logic [11:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         REG_SLOW_INTERVAL: slow_ms = data;
         REG_FAST_INTERVAL: fast_ms = data;
         REG_LONG_PAUSE:    rest_ms = data;
         REG_ZERO_PAUSE:    zero_dark = data[3:0];
         REG_NONZERO_PAUSE: nonzero_dark = data[3:0];
         REG_MAX_HUNDREDS:  hund_max = data[3:0];
         default: ;
      endcase
   endtask

   // offer one beat after a random gap, predict it once accepted
   task automatic send_beat(input req_type b, input logic known, input rsp_type want);
      int unsigned gap;
      rsp_type     due;
      if ($urandom_range(63) == 0) send_eager = ~send_eager;
      gap = send_eager ? 0 : $urandom_range(5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall);
      due = next_led_state(b);
      led_due.push_back(known ? want : due);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (led_due.size() != 0) @(posedge clock);
   endtask

   // stimulus: directed table, then random register settings
   initial begin : stimulus
      req_type     beat;
      int unsigned sent;
      int unsigned goal;
      int unsigned roll;
      logic [11:0] c_slow;
      logic [11:0] c_fast;
      logic [11:0] c_rest;
      logic [3:0]  c_zero;
      logic [3:0]  c_nonzero;
      logic [3:0]  c_max;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].is_csr) begin
            drain();
            write_csr(DIR_ROWS[i].csr_idx, DIR_ROWS[i].csr_val);
         end else begin
            send_beat(DIR_ROWS[i].beat, DIR_ROWS[i].known, DIR_ROWS[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // phase 0 all registers zero, phase 1 all at max, then short timings
         if (p == 0) begin
            c_slow    = '0;
            c_fast    = '0;
            c_rest    = '0;
            c_zero    = '0;
            c_nonzero = '0;
            c_max     = '0;
         end else if (p == 1) begin
            c_slow    = 12'hFFF;
            c_fast    = 12'hFFF;
            c_rest    = 12'hFFF;
            c_zero    = 4'hF;
            c_nonzero = 4'hF;
            c_max     = 4'hF;
         end else begin
            c_slow    = 12'($urandom_range(1, 6));
            c_fast    = 12'($urandom_range(1, 4));
            c_rest    = 12'($urandom_range(1, 12));
            c_zero    = 4'($urandom_range(1, 4));
            c_nonzero = 4'($urandom_range(1, 4));
            c_max     = 4'($urandom_range(15));
         end
         drain();
         write_csr(REG_SLOW_INTERVAL, c_slow);
         write_csr(REG_FAST_INTERVAL, c_fast);
         write_csr(REG_LONG_PAUSE, c_rest);
         write_csr(REG_ZERO_PAUSE, 12'(c_zero));
         write_csr(REG_NONZERO_PAUSE, 12'(c_nonzero));
         write_csr(REG_MAX_HUNDREDS, 12'(c_max));

         // restart, then mostly ticks with loads and restarts mixed in
         sent = 0;
         goal = (p == 1) ? LONG_PHASE_BEATS : PHASE_BEATS;
         while (sent < goal) begin
            roll       = $urandom_range(99);
            beat.value = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1599));
            if (sent == 0) beat.op = OP_RESTART;
            else if (p == 1 || roll < 80) beat.op = OP_TICK;
            else if (roll < 89) beat.op = OP_LOAD;
            else if (roll < 96) beat.op = OP_RESTART;
            else beat.op = OP_UNUSED;
            send_beat(beat, 1'b0, '0);
            if (beat.op != OP_UNUSED) sent++;
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (led_due.size() != 0) begin
         $error("%0d expected results never arrived", led_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off, field checks
   initial begin : result_side
      int unsigned seen;
      int unsigned hold;
      logic        eager;
      rsp_type     want;
      seen  = 0;
      eager = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         hold = 0;
         if (rsp_valid && !rsp_stall) begin
            if (led_due.size() == 0) begin
               $error("result beat %b with no expected result", rsp_payload);
               errors++;
            end else begin
               want = led_due.pop_front();
               if (rsp_payload.led_on !== want.led_on) begin
                  $error("led_on: expected %0b, got %0b", want.led_on, rsp_payload.led_on);
                  errors++;
               end
               if (rsp_payload.showing_tens !== want.showing_tens) begin
                  $error("showing_tens: expected %0b, got %0b",
                         want.showing_tens, rsp_payload.showing_tens);
                  errors++;
               end
               if (rsp_payload.long_rest !== want.long_rest) begin
                  $error("long_rest: expected %0b, got %0b",
                         want.long_rest, rsp_payload.long_rest);
                  errors++;
               end
            end
            seen++;
            if ($urandom_range(63) == 0) eager = ~eager;
            hold = eager ? 0 : $urandom_range(5);
            if (seen == HOLD_AT) hold = HOLD_CYCLES;
         end else if (!eager && $urandom_range(15) == 0) begin
            hold = $urandom_range(1, 5);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
